>>> sv/urd_pkg.sv
// Shared types and constants for the ultrasonic ranger with multiplexed display.
// Used by the design modules of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package urd_pkg;

	localparam int TRIG_W  = 16;
	localparam int HOLD_W  = 24;
	localparam int SCALE_W = 16;
	localparam int TICK_W  = 24;
	localparam int DIST_W  = 10;
	localparam int DIGIT_W = 4;
	localparam int EN_W    = 3;
	localparam int FRAC_BITS = 20;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 8'd2;

	localparam logic [TRIG_W-1:0]  TRIG_RST  = 16'd160;
	localparam logic [HOLD_W-1:0]  HOLD_RST  = 24'd160000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1124;

	localparam logic [DIST_W-1:0] DIST_MAX = 10'd999;

	// Display enable codes.
	localparam logic [EN_W-1:0] EN_NONE = 3'b000;
	localparam logic [EN_W-1:0] EN_HUND = 3'b001;
	localparam logic [EN_W-1:0] EN_TENS = 3'b010;
	localparam logic [EN_W-1:0] EN_ONES = 3'b100;

	// Per-beat control flags carried down the pipeline.
	typedef struct packed {
		logic            trig;
		logic [EN_W-1:0] en;
		logic            done;
	} ctl_t;

endpackage

`default_nettype wire

>>> sv/urd_ctrl.sv
// Input register and phase sequencer: trigger, echo wait, echo count and display hold.
// Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urd_ctrl #(
	parameter int COUNT_BITS = 24
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          echo,
	input  wire [urd_pkg::TRIG_W-1:0]    trigger_ticks,
	input  wire [urd_pkg::HOLD_W-1:0]    hold_ticks,
	output logic                         out_valid,
	input  wire                          out_ready,
	output urd_pkg::ctl_t                out_ctl,
	output logic [COUNT_BITS-1:0]        out_count
);

	localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
	localparam logic [2:0] PH_WAIT      = 3'd2;
	localparam logic [2:0] PH_COUNT     = 3'd3;
	localparam logic [2:0] PH_HUND      = 3'd4;
	localparam logic [2:0] PH_TENS      = 3'd5;
	localparam logic [2:0] PH_ONES      = 3'd6;

	logic                        v_s1;
	logic                        echo_s1;
	logic                        v_s2;
	urd_pkg::ctl_t               ctl_s2;
	logic [COUNT_BITS-1:0]       count_s2;

	logic [2:0]                  phase_q, phase_d;
	logic [urd_pkg::TICK_W-1:0]  tick_q, tick_d, tick_inc, tick_tmr, len;
	logic [COUNT_BITS-1:0]       count_q, count_d;
	logic                        tmr_done;
	urd_pkg::ctl_t               ctl_d;
	logic                        ready_s2, adv;

	assign ready_s2 = !v_s2 || out_ready;
	assign adv      = v_s1 && ready_s2;
	assign in_ready = !v_s1 || adv;

	// The trigger phases time against the trigger length, the display phases against the hold.
	always_comb begin
		if (phase_q == PH_TRIG_LOW || phase_q == PH_TRIG_HIGH) begin
			len = urd_pkg::TICK_W'(trigger_ticks);
		end else begin
			len = hold_ticks;
		end
	end

	assign tick_inc = tick_q + 1'b1;
	assign tmr_done = tick_inc >= len;
	assign tick_tmr = tmr_done ? '0 : tick_inc;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		count_d = count_q;
		ctl_d   = '{trig: 1'b0, en: urd_pkg::EN_NONE, done: 1'b0};
		case (phase_q)
			PH_TRIG_LOW: begin
				tick_d = tick_tmr;
				if (tmr_done) phase_d = PH_TRIG_HIGH;
			end
			PH_TRIG_HIGH: begin
				ctl_d.trig = 1'b1;
				tick_d = tick_tmr;
				if (tmr_done) phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				tick_d = '0;
				if (echo_s1) begin
					count_d = COUNT_BITS'(1);
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				tick_d = '0;
				if (echo_s1) begin
					count_d = count_q + 1'b1;
				end else begin
					ctl_d.done = 1'b1;
					phase_d = PH_HUND;
				end
			end
			PH_HUND: begin
				ctl_d.en = urd_pkg::EN_HUND;
				tick_d = tick_tmr;
				if (tmr_done) phase_d = PH_TENS;
			end
			PH_TENS: begin
				ctl_d.en = urd_pkg::EN_TENS;
				tick_d = tick_tmr;
				if (tmr_done) phase_d = PH_ONES;
			end
			PH_ONES: begin
				ctl_d.en = urd_pkg::EN_ONES;
				tick_d = tick_tmr;
				if (tmr_done) phase_d = PH_TRIG_LOW;
			end
			default: begin
				tick_d = '0;
				phase_d = PH_TRIG_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			phase_q <= PH_TRIG_LOW;
			tick_q  <= '0;
			count_q <= '0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (adv) begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) echo_s1 <= echo;
		if (adv) begin
			ctl_s2   <= ctl_d;
			count_s2 <= count_q;
		end
	end

	assign out_valid = v_s2;
	assign out_ctl   = ctl_s2;
	assign out_count = count_s2;

endmodule

`default_nettype wire

>>> sv/urd_scale.sv
// Echo count to centimetres: registered multiply, then shift and saturate.
// Holds the last latched distance. Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urd_scale #(
	parameter int COUNT_BITS = 24
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  urd_pkg::ctl_t                 in_ctl,
	input  wire [COUNT_BITS-1:0]          in_count,
	input  wire [urd_pkg::SCALE_W-1:0]    scale,
	output logic                          out_valid,
	input  wire                           out_ready,
	output urd_pkg::ctl_t                 out_ctl,
	output logic [urd_pkg::DIST_W-1:0]    out_dist
);

	localparam int PW = COUNT_BITS + urd_pkg::SCALE_W;
	localparam int HW = PW - urd_pkg::FRAC_BITS;

	logic                        v_s3, v_s4;
	urd_pkg::ctl_t               ctl_s3, ctl_s4;
	logic [PW-1:0]               prod_s3;
	logic [urd_pkg::DIST_W-1:0]  dist_s4, dist_sat;
	logic [HW-1:0]               whole;
	logic                        ready_s3, ready_s4, move4;

	assign ready_s4 = !v_s4 || out_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign move4    = v_s3 && ready_s4;
	assign in_ready = ready_s3;

	assign whole    = prod_s3[PW-1:urd_pkg::FRAC_BITS];
	assign dist_sat = (whole > HW'(urd_pkg::DIST_MAX)) ? urd_pkg::DIST_MAX
		: whole[urd_pkg::DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			dist_s4 <= '0;
		end else begin
			if (ready_s3) v_s3 <= in_valid;
			if (ready_s4) v_s4 <= v_s3;
			if (move4 && ctl_s3.done) dist_s4 <= dist_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			ctl_s3  <= in_ctl;
			prod_s3 <= PW'(in_count) * PW'(scale);
		end
		if (move4) ctl_s4 <= ctl_s3;
	end

	assign out_valid = v_s4;
	assign out_ctl   = ctl_s4;
	assign out_dist  = dist_s4;

endmodule

`default_nettype wire

>>> sv/urd_digits.sv
// Decimal split of the distance and selection of the shown digit; ends in the
// output register. Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urd_digits (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  urd_pkg::ctl_t                  in_ctl,
	input  wire [urd_pkg::DIST_W-1:0]      in_dist,
	output logic                           out_valid,
	input  wire                            out_ready,
	output urd_pkg::ctl_t                  out_ctl,
	output logic [urd_pkg::DIGIT_W-1:0]    out_digit,
	output logic [urd_pkg::DIST_W-1:0]     out_dist
);

	// Hundreds by parallel compares against the multiples of one hundred.
	function automatic logic [urd_pkg::DIGIT_W-1:0] hund_of(input logic [urd_pkg::DIST_W-1:0] d);
		logic [urd_pkg::DIGIT_W-1:0] h;
		h = '0;
		for (int i = 1; i < 10; i++) begin
			if (d >= urd_pkg::DIST_W'(i * 100)) h = urd_pkg::DIGIT_W'(i);
		end
		return h;
	endfunction

	function automatic logic [urd_pkg::DIGIT_W-1:0] tens_of(input logic [6:0] r);
		logic [urd_pkg::DIGIT_W-1:0] t;
		t = '0;
		for (int i = 1; i < 10; i++) begin
			if (r >= 7'(i * 10)) t = urd_pkg::DIGIT_W'(i);
		end
		return t;
	endfunction

	logic                          v_s5, v_s6;
	urd_pkg::ctl_t                 ctl_s5, ctl_s6;
	logic [urd_pkg::DIST_W-1:0]    dist_s5, dist_s6;
	logic [urd_pkg::DIGIT_W-1:0]   hund_s5, hund_d, tens, ones, digit_d, digit_s6;
	logic [6:0]                    rem_s5, rem_d;
	logic [urd_pkg::DIST_W-1:0]    rem_w;
	logic [6:0]                    ones_w;
	logic                          ready_s5, ready_s6, move6;

	assign ready_s6 = !v_s6 || out_ready;
	assign ready_s5 = !v_s5 || ready_s6;
	assign move6    = v_s5 && ready_s6;
	assign in_ready = ready_s5;

	assign hund_d = hund_of(in_dist);
	assign rem_w  = in_dist - urd_pkg::DIST_W'(hund_d) * urd_pkg::DIST_W'(100);
	assign rem_d  = rem_w[6:0];

	assign tens   = tens_of(rem_s5);
	assign ones_w = rem_s5 - 7'(tens) * 7'(10);
	assign ones   = ones_w[urd_pkg::DIGIT_W-1:0];

	always_comb begin
		case (ctl_s5.en)
			urd_pkg::EN_HUND: digit_d = hund_s5;
			urd_pkg::EN_TENS: digit_d = tens;
			urd_pkg::EN_ONES: digit_d = ones;
			default:          digit_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ready_s5) v_s5 <= in_valid;
			if (ready_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s5) begin
			ctl_s5  <= in_ctl;
			dist_s5 <= in_dist;
			hund_s5 <= hund_d;
			rem_s5  <= rem_d;
		end
		if (move6) begin
			ctl_s6   <= ctl_s5;
			dist_s6  <= dist_s5;
			digit_s6 <= digit_d;
		end
	end

	assign out_valid = v_s6;
	assign out_ctl   = ctl_s6;
	assign out_digit = digit_s6;
	assign out_dist  = dist_s6;

endmodule

`default_nettype wire

>>> sv/ultrasonic_ranger_display_top.sv
// Ultrasonic ranger with three-digit multiplexed display, top level.
// Throughput: one beat per cycle while m_tready is high; every stage has its own valid bit,
// so bubbles close up. The phase sequencer updates once per accepted beat; one 24x16 multiply
// sets the stage budget.
// Reset (arst_n low, asynchronous): pipeline empty, trigger-low phase, counters and distance
// zero, registers at 160 / 160000 / 1124. Depends on urd_pkg, urd_ctrl, urd_scale, urd_digits.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_ranger_display_top #(
	parameter int COUNT_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input beats: one per clock tick of the sensor timing.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [7:0]   s_tdata,    // [0] echo_level, [7:1] zero
	// Result beats: one per input beat.
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,    // [0] trig, [3:1] digit_enable, [7:4] digit_value,
	                                // [17:8] distance_cm, [23:18] zero
	output logic [0:0]  m_tuser,    // [0] measure_done
	// Register writes.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [urd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [urd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. The user must write them only while the pipeline is empty,
	// which the block itself does not enforce; every stage reads them directly.
	logic [urd_pkg::TRIG_W-1:0]  trig_len_q;
	logic [urd_pkg::HOLD_W-1:0]  hold_q;
	logic [urd_pkg::SCALE_W-1:0] scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_len_q <= urd_pkg::TRIG_RST;
			hold_q     <= urd_pkg::HOLD_RST;
			scale_q    <= urd_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				urd_pkg::CFG_TRIGGER: trig_len_q <= cfg_data[urd_pkg::TRIG_W-1:0];
				urd_pkg::CFG_HOLD:    hold_q     <= cfg_data[urd_pkg::HOLD_W-1:0];
				urd_pkg::CFG_SCALE:   scale_q    <= cfg_data[urd_pkg::SCALE_W-1:0];
				default: ; // Unknown indexes are dropped.
			endcase
		end
	end

	// Sequencer: input register, then the phase machine feeding stage two.
	logic                  c_valid, c_ready;
	urd_pkg::ctl_t         c_ctl;
	logic [COUNT_BITS-1:0] c_count;

	urd_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.echo          (s_tdata[0]),
		.trigger_ticks (trig_len_q),
		.hold_ticks    (hold_q),
		.out_valid     (c_valid),
		.out_ready     (c_ready),
		.out_ctl       (c_ctl),
		.out_count     (c_count)
	);

	// Scaling: the multiply is registered, then shifted and clamped to 999 cm.
	logic                        d_valid, d_ready;
	urd_pkg::ctl_t               d_ctl;
	logic [urd_pkg::DIST_W-1:0]  d_dist;

	urd_scale #(.COUNT_BITS(COUNT_BITS)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_ctl    (c_ctl),
		.in_count  (c_count),
		.scale     (scale_q),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_ctl   (d_ctl),
		.out_dist  (d_dist)
	);

	// Decimal split and digit multiplexing, ending in the output register.
	urd_pkg::ctl_t                o_ctl;
	logic [urd_pkg::DIGIT_W-1:0]  o_digit;
	logic [urd_pkg::DIST_W-1:0]   o_dist;

	urd_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_ctl    (d_ctl),
		.in_dist   (d_dist),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ctl   (o_ctl),
		.out_digit (o_digit),
		.out_dist  (o_dist)
	);

	assign m_tdata = {6'b0, o_dist, o_digit, o_ctl.en, o_ctl.trig};
	assign m_tuser = o_ctl.done;

endmodule

`default_nettype wire

>>> sv/urd_checker.sv
// Port-level checks on the ranger's result beats, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module urd_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [23:0]  m_tdata,
	input wire [0:0]   m_tuser
);

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// At most one display is enabled, and never while the trigger is driven.
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[3:1]) && !(m_tdata[0] && (m_tdata[3:1] != 3'b000)))
		else $error("display enables overlap or collide with trigger");

	// A latch beat comes from the count phase: no trigger, no display.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'h00)
		else $error("measurement latched outside the count phase");

	// The shown digit is decimal and blank when no display is enabled.
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] <= 4'd9 && (m_tdata[3:1] != 3'b000 || m_tdata[7:4] == 4'd0))
		else $error("digit value out of range");

	// The distance is clamped.
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:8] <= 10'd999 && m_tdata[23:18] == 6'd0)
		else $error("distance beyond 999 cm");

endmodule

bind ultrasonic_ranger_display_top urd_checker u_urd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
